// ----- design/kpd_pkg.sv -----
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants for the keypad scan / debounce / key FIFO block.
// ----------------------------------------------------------------------------
package kpd_pkg;

   // Request codes carried in the req_type field
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_PRESS = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_NOP   = 2'd3;

   localparam logic [7:0] QUIET_TICKS_RESET = 8'd10;
   localparam logic [3:0] ROWS_ALL_HIGH     = 4'hF;

   // Keycap ASCII for scan code row*4+col: "123A456B789C*0#D"
   localparam logic [6:0] KEY_CAP [16] = '{
      7'h31, 7'h32, 7'h33, 7'h41,
      7'h34, 7'h35, 7'h36, 7'h42,
      7'h37, 7'h38, 7'h39, 7'h43,
      7'h2A, 7'h30, 7'h23, 7'h44
   };

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  idle_rows;
      logic [15:0] scan_rows;
   } kpd_req_type;

   typedef struct packed {
      logic       key_valid;
      logic [6:0] key_char;
      logic [3:0] key_code;
      logic       key_waiting;
      logic       press_armed;
      logic       press_dropped;
   } kpd_rsp_type;

   // Control into the key FIFO
   typedef struct packed {
      logic       push;
      logic       pop;
      logic [3:0] wdata;
   } kpd_fifo_ctl_type;

   // Status out of the key FIFO
   typedef struct packed {
      logic       empty;
      logic       full;
      logic       one_left;   // exactly one code stored
      logic [3:0] head;
   } kpd_fifo_stat_type;

endpackage

// ----- design/kpd_scan.sv -----
// ----------------------------------------------------------------------------
// kpd_scan
// Column scan encoder: first column with a low row, highest low row in it.
// ----------------------------------------------------------------------------
module kpd_scan (
   input  logic [15:0] scan_rows,
   output logic        found,
   output logic [3:0]  code
);
   import kpd_pkg::*;

   logic [3:0] low_rows [4];
   logic [1:0] row_sel  [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         low_rows[c] = ~scan_rows[4*c +: 4];
         priority if (low_rows[c][3]) begin
            row_sel[c] = 2'd3;
         end else if (low_rows[c][2]) begin
            row_sel[c] = 2'd2;
         end else if (low_rows[c][1]) begin
            row_sel[c] = 2'd1;
         end else begin
            row_sel[c] = 2'd0;
         end
      end
   end

   // Column 0 has priority
   always_comb begin
      found = 1'b1;
      priority if (low_rows[0] != 4'h0) begin
         code = {row_sel[0], 2'd0};
      end else if (low_rows[1] != 4'h0) begin
         code = {row_sel[1], 2'd1};
      end else if (low_rows[2] != 4'h0) begin
         code = {row_sel[2], 2'd2};
      end else if (low_rows[3] != 4'h0) begin
         code = {row_sel[3], 2'd3};
      end else begin
         found = 1'b0;
         code  = 4'h0;
      end
   end

endmodule

// ----- design/kpd_fifo.sv -----
// ----------------------------------------------------------------------------
// kpd_fifo
// Key code FIFO holding up to FIFO_DEPTH-1 codes, registered head read.
// ----------------------------------------------------------------------------
module kpd_fifo #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kpd_pkg::kpd_fifo_ctl_type  ctl,
   output kpd_pkg::kpd_fifo_stat_type stat
);
   import kpd_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   logic [3:0]       mem [FIFO_DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_inc, wr_ptr_inc;
   logic [3:0]       head_ff;

   assign rd_ptr_inc = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign wr_ptr_inc = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;

   assign rd_ptr_in = ctl.pop  ? rd_ptr_inc : rd_ptr_ff;
   assign wr_ptr_in = ctl.push ? wr_ptr_inc : wr_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_ptr_ff] <= ctl.wdata;
      end
   end

   // Head prefetch at the next read pointer, bypassing a same-cycle write
   always_ff @(posedge clock) begin
      if (ctl.push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= ctl.wdata;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   assign stat.empty    = (rd_ptr_ff == wr_ptr_ff);
   assign stat.full     = (wr_ptr_inc == rd_ptr_ff);
   assign stat.one_left = (rd_ptr_inc == wr_ptr_ff);
   assign stat.head     = head_ff;

endmodule

// ----- design/keypad_scan_debounce_fifo.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_debounce_fifo
// 4x4 matrix keypad controller: debounce, column scan and key code FIFO.
//
//   channel | ports                          | direction | payload
//   --------+--------------------------------+-----------+------------------
//   request | req_valid req_ready req_data   | in        | kpd_req_type
//   result  | rsp_valid rsp_ready rsp_data   | out       | kpd_rsp_type
//   csr     | csr_valid csr_ready csr_data   | in        | quiet_ticks, 8 b
//
// One transaction per cycle sustained while results are taken; an accepted
// request passes the input register, then the result register. The whole step
// is one pass of scan encode, FIFO push/pop and debounce update between them.
// Synchronous active-high reset: debounce mode, quiet count 0, FIFO empty,
// quiet_ticks 10. No clearing pass; FIFO entries are only read once written.
// A stalled result register stalls the input register; csr_ready is always 1.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_fifo #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kpd_pkg::kpd_req_type req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kpd_pkg::kpd_rsp_type rsp_data,
   // configuration write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_data
);
   import kpd_pkg::*;

   // input register
   logic        in_valid_ff, in_valid_in;
   kpd_req_type in_data_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   kpd_rsp_type rsp_data_ff, rsp_data_in;

   // block state
   logic [7:0]  quiet_ticks_ff;
   logic [7:0]  quiet_count_ff, quiet_count_in;
   logic        armed_ff, armed_in;
   logic [7:0]  quiet_count_inc;

   logic        advance;       // the item in the input register completes
   logic        scan_found;
   logic [3:0]  scan_code;

   kpd_fifo_ctl_type  fifo_ctl;
   kpd_fifo_stat_type fifo_stat;

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 :
                         (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_ticks_ff <= QUIET_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         quiet_ticks_ff <= csr_data;
      end
   end

   // ------------------------------------------------------------------------
   // Datapath units
   // ------------------------------------------------------------------------
   kpd_scan u_scan (
      .scan_rows (in_data_ff.scan_rows),
      .found     (scan_found),
      .code      (scan_code)
   );

   kpd_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .ctl   (fifo_ctl),
      .stat  (fifo_stat)
   );

   // 8-bit counter wraps, so quiet_ticks of zero arms after 256 ticks
   assign quiet_count_inc = quiet_count_ff + 8'd1;

   // ------------------------------------------------------------------------
   // Step: decode the request, update debounce state, drive the FIFO
   // ------------------------------------------------------------------------
   always_comb begin
      quiet_count_in = quiet_count_ff;
      armed_in       = armed_ff;
      fifo_ctl       = '0;
      fifo_ctl.wdata = scan_code;
      rsp_data_in    = '0;

      if (advance) begin
         unique case (in_data_ff.req_type)
            REQ_TICK: begin
               // ticks are ignored once armed
               if (!armed_ff) begin
                  if (in_data_ff.idle_rows != ROWS_ALL_HIGH) begin
                     quiet_count_in = '0;
                  end else if (quiet_count_inc == quiet_ticks_ff) begin
                     quiet_count_in = '0;
                     armed_in       = 1'b1;
                  end else begin
                     quiet_count_in = quiet_count_inc;
                  end
               end
            end
            REQ_PRESS: begin
               // no low row anywhere: stay armed, nothing pushed
               if (armed_ff && scan_found) begin
                  if (fifo_stat.full) begin
                     rsp_data_in.press_dropped = 1'b1;
                  end else begin
                     fifo_ctl.push = 1'b1;
                  end
                  armed_in = 1'b0;
               end
            end
            REQ_READ: begin
               // empty FIFO: report not-valid, no state change
               if (!fifo_stat.empty) begin
                  fifo_ctl.pop          = 1'b1;
                  rsp_data_in.key_valid = 1'b1;
                  rsp_data_in.key_code  = fifo_stat.head;
                  rsp_data_in.key_char  = KEY_CAP[fifo_stat.head];
               end
            end
            REQ_NOP: begin
               // status only
            end
            default: begin
            end
         endcase
      end

      // occupancy after this step; push and pop never coincide
      rsp_data_in.key_waiting = fifo_ctl.push ||
                                (fifo_ctl.pop ? !fifo_stat.one_left : !fifo_stat.empty);
      rsp_data_in.press_armed = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_count_ff <= '0;
         armed_ff       <= 1'b0;
      end else begin
         quiet_count_ff <= quiet_count_in;
         armed_ff       <= armed_in;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef SYNTHESIS
   // popped character always matches the popped code
   a_char_matches_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.key_valid) |-> (rsp_data.key_char == KEY_CAP[rsp_data.key_code]))
      else $error("key_char does not match key_code");

   // no key popped: character and code are zero
   a_empty_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.key_valid) |->
         (rsp_data.key_char == 7'd0 && rsp_data.key_code == 4'd0))
      else $error("key fields nonzero without key_valid");

   // a dropped press always returns the block to debounce mode
   a_drop_disarms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.press_dropped) |-> !rsp_data.press_armed)
      else $error("press dropped while still armed");

   // quiet counter is held at zero while armed
   a_armed_count_zero: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (quiet_count_ff == 8'd0))
      else $error("quiet count nonzero while armed");

   // a completed step always presents a result next cycle
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("completed step produced no result");
`endif

endmodule

// ----- tb/tb_keypad_scan_debounce_fifo.sv -----
// ----------------------------------------------------------------------------
// tb_keypad_scan_debounce_fifo
// Self-checking bench for the keypad debounce / column scan / key FIFO block.
// A table of opening steps covers reset state, every request kind, the scan
// priority corners and the ignored-request cases. Randomized phases follow,
// mostly well-formed debounce -> press -> read sequences, with noise mixed in.
// Every result transaction is checked, against an in-bench model of the block or a pinned value.
// ----------------------------------------------------------------------------
module tb_keypad_scan_debounce_fifo;
   timeunit 1ns;
   timeprecision 1ps;

   import kpd_pkg::*;

   localparam int           FIFO_DEPTH     = 16;
   localparam int           KEY_SLOTS      = FIFO_DEPTH - 1;  // one slot stays empty
   localparam int           SHAPED_TARGET  = 1500;
   localparam int           PHASE_ITEMS    = 120;
   localparam int           RSP_HOLD_LEN   = 300;
   localparam int           WATCHDOG_LIMIT = 2000;
   localparam int           DRAIN_CYCLES   = 4;
   // keycap for code row*4+col, code 0 in the top byte
   localparam bit [127:0]   KEYCAPS        = "123A456B789C*0#D";

   localparam kpd_rsp_type  RSP_IDLE       = '0;
   localparam kpd_rsp_type  RSP_ARMED_ONLY = '{1'b0, 7'h00, 4'h0, 1'b0, 1'b1, 1'b0};

   typedef struct {
      kpd_req_type stim;
      int          reps;
      bit          pinned;      // expectation typed in below, not modeled
      kpd_rsp_type pinned_rsp;
   } step_row_type;

   localparam int OPENING_ROWS = 21;

   // Opening steps. Default quiet_ticks (10) is in effect throughout.
   step_row_type opening [OPENING_ROWS] = '{
      // empty FIFO read right out of reset
      '{'{REQ_READ,  4'hF, 16'hFFFF},  1, 1'b1, RSP_IDLE},
      // no-op with every field low
      '{'{REQ_NOP,   4'h0, 16'h0000},  1, 1'b1, RSP_IDLE},
      // press while in debounce mode is ignored
      '{'{REQ_PRESS, 4'hF, 16'h0000},  1, 1'b1, RSP_IDLE},
      '{'{REQ_TICK,  4'h0, 16'hFFFF},  1, 1'b1, RSP_IDLE},
      '{'{REQ_TICK,  4'hF, 16'hFFFF},  9, 1'b0, RSP_IDLE},
      // a bounce one tick short of arming restarts the count
      '{'{REQ_TICK,  4'hE, 16'hFFFF},  1, 1'b1, RSP_IDLE},
      '{'{REQ_TICK,  4'hF, 16'hFFFF}, 10, 1'b0, RSP_IDLE},
      // tick while armed is ignored
      '{'{REQ_TICK,  4'h0, 16'h0000},  1, 1'b1, RSP_ARMED_ONLY},
      // press with nothing low keeps the block armed
      '{'{REQ_PRESS, 4'h0, 16'hFFFF},  1, 1'b1, RSP_ARMED_ONLY},
      // everything low: column 0 wins, highest row wins -> '*'
      '{'{REQ_PRESS, 4'hF, 16'h0000},  1, 1'b0, RSP_IDLE},
      '{'{REQ_READ,  4'hF, 16'hFFFF},  1, 1'b1, '{1'b1, 7'h2A, 4'd12, 1'b0, 1'b0, 1'b0}},
      '{'{REQ_TICK,  4'hF, 16'hFFFF}, 10, 1'b0, RSP_IDLE},
      // last column, last row only
      '{'{REQ_PRESS, 4'hF, 16'h7FFF},  1, 1'b0, RSP_IDLE},
      '{'{REQ_TICK,  4'hF, 16'hFFFF}, 10, 1'b0, RSP_IDLE},
      // first column, first row only
      '{'{REQ_PRESS, 4'hF, 16'hFFFE},  1, 1'b0, RSP_IDLE},
      '{'{REQ_TICK,  4'hF, 16'hFFFF}, 10, 1'b0, RSP_IDLE},
      // two rows low in column 2: the higher row is taken
      '{'{REQ_PRESS, 4'hF, 16'hFAFF},  1, 1'b0, RSP_IDLE},
      '{'{REQ_NOP,   4'hF, 16'hFFFF},  1, 1'b0, RSP_IDLE},
      '{'{REQ_READ,  4'h0, 16'h0000},  3, 1'b0, RSP_IDLE},
      '{'{REQ_READ,  4'hF, 16'hFFFF},  1, 1'b1, RSP_IDLE},
      '{'{REQ_TICK,  4'h5, 16'h1234},  1, 1'b1, RSP_IDLE}
   };

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   kpd_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   kpd_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data  = '0;

   // model state
   logic [7:0]  arm_target   = QUIET_TICKS_RESET;
   logic [7:0]  debounce_run = '0;
   bit          press_live   = 1'b0;
   logic [3:0]  key_queue[$];

   kpd_rsp_type pending_rsp[$];      // expected result transactions, oldest first
   int          mismatch_count = 0;
   int          shaped_items   = 0;
   bit          stall_en       = 1'b1;
   int          hold_asks      = 0;  // bumped by the stimulus to request a long hold
   int          hold_seen      = 0;
   int          hold_left      = 0;
   int          quiet_cycles   = 0;

   keypad_scan_debounce_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Model of one accepted request: updates state, returns the expected result.
   function automatic kpd_rsp_type predict_key_step(kpd_req_type stim);
      kpd_rsp_type rsp;
      logic [3:0]  low_rows;
      logic [3:0]  code;
      bit          found;
      rsp   = '0;
      code  = '0;
      found = 1'b0;
      case (stim.req_type)
         REQ_TICK: begin
            // ignored once armed
            if (!press_live) begin
               if (stim.idle_rows != ROWS_ALL_HIGH) begin
                  debounce_run = '0;
               end else begin
                  debounce_run = debounce_run + 8'd1;   // 8-bit wrap is intended
                  if (debounce_run == arm_target) begin
                     debounce_run = '0;
                     press_live   = 1'b1;
                  end
               end
            end
         end
         REQ_PRESS: begin
            if (press_live) begin
               // first column with any low row, then the highest low row in it
               for (int col = 0; col < 4; col++) begin
                  low_rows = ~stim.scan_rows[4*col +: 4];
                  for (int row = 3; row >= 0; row--) begin
                     if (!found && low_rows[row]) begin
                        found = 1'b1;
                        code  = 4'(row * 4 + col);
                     end
                  end
               end
               if (found) begin
                  if (key_queue.size() == KEY_SLOTS) rsp.press_dropped = 1'b1;
                  else key_queue.push_back(code);
                  press_live = 1'b0;
               end
            end
         end
         REQ_READ: begin
            if (key_queue.size() != 0) begin
               code          = key_queue.pop_front();
               rsp.key_valid = 1'b1;
               rsp.key_code  = code;
               rsp.key_char  = KEYCAPS[8*(15 - code) +: 7];
            end
         end
         default: begin
         end
      endcase
      rsp.key_waiting = (key_queue.size() != 0);
      rsp.press_armed = press_live;
      return rsp;
   endfunction

   task automatic log_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
   endtask

   // Offer one request transaction; returns at the edge it is accepted.
   task automatic send_item(kpd_req_type stim, bit pinned, kpd_rsp_type pinned_rsp);
      kpd_rsp_type modeled;
      @(negedge clock);
      if (stall_en) begin
         while ($urandom_range(0, 99) < 30) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= stim;
      do @(posedge clock); while (req_ready !== 1'b1);
      modeled = predict_key_step(stim);
      pending_rsp.push_back(pinned ? pinned_rsp : modeled);
   endtask

   // Drop valid and wait for every outstanding result; block is idle after.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Called after settle, at a falling edge, with the block idle.
   task automatic write_quiet_ticks(logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      arm_target = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: random back-pressure, plus one long hold on request.
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = RSP_HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !stall_en || ($urandom_range(0, 99) >= 30);
      end
   end

   // Result checker: in-order compare against the oldest expectation.
   always @(posedge clock) begin
      kpd_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            log_mismatch("unexpected result", rsp_data, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.key_valid !== want.key_valid)
               log_mismatch("key_valid", rsp_data.key_valid, want.key_valid);
            if (rsp_data.key_char !== want.key_char)
               log_mismatch("key_char", rsp_data.key_char, want.key_char);
            if (rsp_data.key_code !== want.key_code)
               log_mismatch("key_code", rsp_data.key_code, want.key_code);
            if (rsp_data.key_waiting !== want.key_waiting)
               log_mismatch("key_waiting", rsp_data.key_waiting, want.key_waiting);
            if (rsp_data.press_armed !== want.press_armed)
               log_mismatch("press_armed", rsp_data.press_armed, want.press_armed);
            if (rsp_data.press_dropped !== want.press_dropped)
               log_mismatch("press_dropped", rsp_data.press_dropped, want.press_dropped);
         end
      end
   end

   // Watchdog: too long with no transaction on any channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      kpd_req_type stim;
      int          phase;
      int          phase_start;
      int          tick_idx;
      int          bounce_at;
      int          reads;
      bit          producer;
      logic [7:0]  ticks;

      // reset: released on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- opening table ----
      foreach (opening[i]) begin
         repeat (opening[i].reps) begin
            send_item(opening[i].stim, opening[i].pinned, opening[i].pinned_rsp);
         end
      end

      // ---- randomized phases ----
      phase = 0;
      while (shaped_items < SHAPED_TARGET) begin
         // Phase 2 leaves a few quiet ticks counted under the slow setting,
         // then lowers quiet_ticks below that count so the counter must wrap.
         if (phase == 2 && !press_live) begin
            repeat (4) send_item('{REQ_TICK, ROWS_ALL_HIGH, 16'($urandom)}, 1'b0, RSP_IDLE);
         end
         settle();
         case (phase)
            0:       ticks = 8'd1;
            1:       ticks = 8'd255;
            2:       ticks = 8'd2;
            default: ticks = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                         : 8'($urandom_range(1, 6));
         endcase
         write_quiet_ticks(ticks);

         stall_en = (phase != 3);          // phase 3: no idling on either side
         if (phase == 4) hold_asks++;      // phase 4: long result hold, input backs up
         // producer phases fill the FIFO into drops, the others drain it dry
         producer = (phase % 2 == 0);

         phase_start = shaped_items;
         while (shaped_items - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
               // noise: any request kind, any field contents
               stim = 22'($urandom);
               send_item(stim, 1'b0, RSP_IDLE);
               continue;
            end

            // debounce until armed, with an occasional bounce along the way
            bounce_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : -1;
            tick_idx  = 0;
            while (!press_live) begin
               stim.req_type  = REQ_TICK;
               stim.idle_rows = (tick_idx == bounce_at) ? 4'($urandom_range(0, 14))
                                                        : ROWS_ALL_HIGH;
               stim.scan_rows = 16'($urandom);
               send_item(stim, 1'b0, RSP_IDLE);
               shaped_items++;
               tick_idx++;
            end

            // press: mostly one clear low bit, sometimes a noisy matrix,
            // sometimes nothing low at all
            stim.req_type  = REQ_PRESS;
            stim.idle_rows = 4'($urandom);
            case ($urandom_range(0, 9))
               0:       stim.scan_rows = 16'hFFFF;
               1, 2, 3: stim.scan_rows = 16'($urandom);
               default: stim.scan_rows = 16'hFFFF;
            endcase
            if (stim.scan_rows != 16'hFFFF || $urandom_range(0, 9) != 0) begin
               stim.scan_rows[$urandom_range(0, 15)] = 1'b0;
            end
            send_item(stim, 1'b0, RSP_IDLE);
            shaped_items++;

            reads = producer ? int'($urandom_range(0, 3) == 0) : $urandom_range(0, 3);
            repeat (reads) begin
               stim.req_type  = REQ_READ;
               stim.idle_rows = 4'($urandom);
               stim.scan_rows = 16'($urandom);
               send_item(stim, 1'b0, RSP_IDLE);
               shaped_items++;
            end
         end
         phase++;
      end

      // ---- wind down ----
      stall_en = 1'b1;
      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
